FILE: src/ssch_pkg.sv
// Stride scheduler package: field widths, payload structs, table entry layout.
// No dependencies; used by ssch_div, stride_scheduler_core and the testbench.
package ssch_pkg;

    localparam int ID_W     = 8;
    localparam int SLOT_W   = 3;
    localparam int PRIO_W   = 8;
    localparam int WORK_W   = 16;
    localparam int STRIDE_W = 16;
    localparam int PASS_W   = 16;

    localparam int TABLE_SLOTS_DEF = 8;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(100);
    localparam logic [PASS_W-1:0]   PASS_LIMIT   = {PASS_W{1'b1}};

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_OK       = 1'b0,
        ST_REJECTED = 1'b1
    } status_t;

    typedef struct packed
    {
        logic [0:0]        operation;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   process_id;
        logic [PRIO_W-1:0] priority_req;
        logic [WORK_W-1:0] work_units;
    } req_t;

    typedef struct packed
    {
        logic [ID_W-1:0]   selected_id;
        logic [SLOT_W-1:0] selected_slot;
        logic [0:0]        idle;
        logic [0:0]        status;
    } rsp_t;

    typedef struct packed
    {
        logic [ID_W-1:0]     ident;
        logic [STRIDE_W-1:0] stride;
        logic [PASS_W-1:0]   pass;
        logic [WORK_W-1:0]   work_left;
    } entry_t;

endpackage

FILE: src/ssch_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/ssch_div.sv
// Restoring divider, one quotient bit per cycle: stride = constant / priority.
// Depends on ssch_pkg for widths.
module ssch_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ssch_pkg::STRIDE_W-1:0] dividend,
    input  logic [ssch_pkg::PRIO_W-1:0]   divisor,
    output logic                          done,
    output logic [ssch_pkg::STRIDE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(ssch_pkg::STRIDE_W + 1);

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg, done_next;
    logic [ssch_pkg::STRIDE_W-1:0] quo_reg, quo_next;
    logic [ssch_pkg::PRIO_W-1:0]   rem_reg, rem_next;
    logic [ssch_pkg::PRIO_W-1:0]   div_reg, div_next;
    logic [ssch_pkg::PRIO_W:0]     trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[ssch_pkg::STRIDE_W-1]};

        if (start)
        begin
            cnt_next = CNT_W'(ssch_pkg::STRIDE_W);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so it fits PRIO_W bits
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = ssch_pkg::PRIO_W'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[ssch_pkg::STRIDE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[ssch_pkg::PRIO_W-1:0];
                quo_next = {quo_reg[ssch_pkg::STRIDE_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/stride_scheduler_core.sv
// Stride scheduler top level: sequencer, slot table RAM, divider, compare unit.
// Load beat: accept, divide, write the table entry, output; zero priority is rejected without a divide.
// Tick beat: read every slot, compare, update the winner, output; one table RAM read port, one compare per slot.
// One beat in flight; a finished result waits in the output register meanwhile.
// Reset clears valid bits, stride constant (to 100) and handshake state; RAM is not cleared.
// Depends on ssch_pkg, ssch_ram, ssch_div.
module stride_scheduler_core #(
    parameter int TABLE_SLOTS = ssch_pkg::TABLE_SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  ssch_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output ssch_pkg::rsp_t                rsp,
    input  logic                          cfg_wr_en,
    input  logic [ssch_pkg::STRIDE_W-1:0] cfg_wr_data
);

    localparam int IDXW = $clog2(TABLE_SLOTS);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(TABLE_SLOTS - 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_LAST,
        S_UPDATE,
        S_FINISH
    } state_t;

    state_t                        state_reg, state_next;
    logic [ssch_pkg::STRIDE_W-1:0] stride_k_reg, stride_k_next;
    ssch_pkg::req_t                req_reg, req_next;
    logic [TABLE_SLOTS-1:0]        valid_reg, valid_next;
    logic [IDXW-1:0]               scan_idx_reg, scan_idx_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic [IDXW-1:0]               rd_idx_reg, rd_idx_next;
    logic                          found_reg, found_next;
    logic [IDXW-1:0]               best_idx_reg, best_idx_next;
    logic [ssch_pkg::PASS_W-1:0]   best_key_reg, best_key_next;
    ssch_pkg::entry_t              best_reg, best_next;
    ssch_pkg::rsp_t                res_reg, res_next;
    logic                          rsp_valid_reg, rsp_valid_next;
    ssch_pkg::rsp_t                rsp_reg, rsp_next;

    logic                          ram_we;
    logic [IDXW-1:0]               ram_waddr;
    ssch_pkg::entry_t              ram_wdata;
    logic [IDXW-1:0]               ram_raddr;
    ssch_pkg::entry_t              ram_rdata;

    logic                          div_start;
    logic                          div_done;
    logic [ssch_pkg::STRIDE_W-1:0] div_quot;

    logic [ssch_pkg::PASS_W-1:0]   cand_key;
    logic                          cand_take;
    logic [ssch_pkg::PASS_W:0]     pass_sum;
    logic                          slot_in_range;

    ssch_ram #(
        .WIDTH ($bits(ssch_pkg::entry_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ssch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (stride_k_reg),
        .divisor  (req.priority_req),
        .done     (div_done),
        .quotient (div_quot)
    );

    // compare unit: one table entry per cycle as read data comes back
    assign cand_key  = (ram_rdata.pass == '0) ? ram_rdata.stride : ram_rdata.pass;
    assign cand_take = rd_vld_reg && valid_reg[rd_idx_reg] && (ram_rdata.work_left != '0)
                       && (!found_reg || (cand_key < best_key_reg));

    assign pass_sum      = {1'b0, best_reg.pass} + {1'b0, best_reg.stride};
    assign slot_in_range = 32'(req.slot) < TABLE_SLOTS;

    always_comb
    begin
        state_next     = state_reg;
        stride_k_next  = stride_k_reg;
        req_next       = req_reg;
        valid_next     = valid_reg;
        scan_idx_next  = scan_idx_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        best_next      = best_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = best_reg;
        ram_raddr      = scan_idx_reg;
        div_start      = 1'b0;

        if (cfg_wr_en)
        begin
            stride_k_next = cfg_wr_data;
        end

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cand_take)
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_key_next = cand_key;
            best_next     = ram_rdata;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    found_next    = 1'b0;
                    scan_idx_next = '0;
                    res_next      = '0;
                    if (req.operation == ssch_pkg::OP_TICK)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (req.priority_req == '0)
                    begin
                        res_next.status = ssch_pkg::ST_REJECTED;
                        state_next      = S_FINISH;
                    end
                    else if (slot_in_range)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = IDXW'(req_reg.slot);
                    ram_wdata.ident         = req_reg.process_id;
                    ram_wdata.stride        = div_quot;
                    ram_wdata.pass          = '0;
                    ram_wdata.work_left     = req_reg.work_units;
                    valid_next[IDXW'(req_reg.slot)] = 1'b1;
                    state_next              = S_FINISH;
                end
            end

            S_SCAN:
            begin
                rd_vld_next = 1'b1;
                rd_idx_next = scan_idx_reg;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end

            S_LAST:
            begin
                // last read beat is compared this cycle
                state_next = S_UPDATE;
            end

            S_UPDATE:
            begin
                if (found_reg)
                begin
                    ram_we                 = 1'b1;
                    ram_wdata.pass         = pass_sum[ssch_pkg::PASS_W] ? ssch_pkg::PASS_LIMIT
                                                                        : pass_sum[ssch_pkg::PASS_W-1:0];
                    ram_wdata.work_left    = best_reg.work_left - 1'b1;
                    res_next.selected_id   = best_reg.ident;
                    res_next.selected_slot = ssch_pkg::SLOT_W'(best_idx_reg);
                end
                else
                begin
                    res_next.idle = 1'b1;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stride_k_reg  <= ssch_pkg::STRIDE_RESET;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stride_k_reg  <= stride_k_next;
            valid_reg     <= valid_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        scan_idx_reg <= scan_idx_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: test/stride_scheduler_core_test.sv
`timescale 1ns / 100ps
// Testbench for stride_scheduler_core: directed and random load/tick beats,
// scheduler prediction and in-order result checking. Depends on ssch_pkg and the core.
module stride_scheduler_core_test;

    localparam int SLOTS = ssch_pkg::TABLE_SLOTS_DEF;
    localparam int REQ_W = $bits(ssch_pkg::req_t);

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    ssch_pkg::req_t                req = '0;
    logic                          rsp_valid;
    logic                          rsp_stall = 1'b0;
    ssch_pkg::rsp_t                rsp;
    logic                          cfg_wr_en = 1'b0;
    logic [ssch_pkg::STRIDE_W-1:0] cfg_wr_data = '0;

    // scheduler shadow state
    logic [ssch_pkg::STRIDE_W-1:0] stride_const = ssch_pkg::STRIDE_RESET;
    logic                          tbl_valid [SLOTS] = '{default: 1'b0};
    logic [ssch_pkg::ID_W-1:0]     tbl_ident [SLOTS];
    logic [ssch_pkg::STRIDE_W-1:0] tbl_stride [SLOTS];
    logic [ssch_pkg::PASS_W-1:0]   tbl_pass [SLOTS];
    logic [ssch_pkg::WORK_W-1:0]   tbl_work [SLOTS];

    ssch_pkg::rsp_t pending_rsp_q [$];
    ssch_pkg::rsp_t sched_exp;
    int unsigned    mismatch_count = 0;
    int unsigned    send_idle_pct = 0;
    int unsigned    rsp_stall_pct = 0;

    stride_scheduler_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_200_000;
        $display("stride_scheduler_core_test NOT OK");
        $finish;
    end

    // Applies one accepted beat to the shadow table and returns its result.
    function automatic ssch_pkg::rsp_t sched_predict(input ssch_pkg::req_t r);
        ssch_pkg::rsp_t res;
        int             best;
        int unsigned    best_key;
        int unsigned    key;
        int unsigned    sum;
        res = '0;
        best = -1;
        best_key = 0;
        if (ssch_pkg::op_t'(r.operation) == ssch_pkg::OP_LOAD)
        begin
            if (r.priority_req == '0)
            begin
                res.status = ssch_pkg::ST_REJECTED;
            end
            else
            begin
                tbl_valid[r.slot]  = 1'b1;
                tbl_ident[r.slot]  = r.process_id;
                tbl_stride[r.slot] = stride_const / r.priority_req;
                tbl_pass[r.slot]   = '0;
                tbl_work[r.slot]   = r.work_units;
            end
            return res;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_work[i] != '0)
            begin
                // fresh entries compete with their stride
                key = (tbl_pass[i] == '0) ? 32'(tbl_stride[i]) : 32'(tbl_pass[i]);
                if (best < 0 || key < best_key)
                begin
                    best = i;
                    best_key = key;
                end
            end
        end
        if (best < 0)
        begin
            res.idle = 1'b1;
            return res;
        end
        sum = 32'(tbl_pass[best]) + 32'(tbl_stride[best]);
        tbl_pass[best] = (sum > ssch_pkg::PASS_LIMIT) ? ssch_pkg::PASS_LIMIT
                                                      : ssch_pkg::PASS_W'(sum);
        tbl_work[best] = tbl_work[best] - 1'b1;
        res.selected_id   = tbl_ident[best];
        res.selected_slot = ssch_pkg::SLOT_W'(best);
        return res;
    endfunction

    function automatic ssch_pkg::req_t load_item(input int unsigned slot, input int unsigned id,
                                                 input int unsigned prio,
                                                 input int unsigned work);
        ssch_pkg::req_t r;
        r = '0;
        r.operation    = ssch_pkg::OP_LOAD;
        r.slot         = ssch_pkg::SLOT_W'(slot);
        r.process_id   = ssch_pkg::ID_W'(id);
        r.priority_req = ssch_pkg::PRIO_W'(prio);
        r.work_units   = ssch_pkg::WORK_W'(work);
        return r;
    endfunction

    // Tick beats carry random junk in the unused fields.
    function automatic ssch_pkg::req_t tick_item();
        ssch_pkg::req_t r;
        r = ssch_pkg::req_t'(REQ_W'({$urandom, $urandom}));
        r.operation = ssch_pkg::OP_TICK;
        return r;
    endfunction

    function automatic ssch_pkg::req_t random_item();
        int unsigned pick;
        int unsigned prio;
        int unsigned work;
        if ($urandom_range(99) >= 30)
            return tick_item();
        pick = $urandom_range(99);
        if (pick < 5)
            prio = 0;
        else if (pick < 55)
            prio = $urandom_range(1, 8);
        else
            prio = $urandom_range(1, 255);
        pick = $urandom_range(99);
        if (pick < 10)
            work = 0;
        else if (pick < 90)
            work = $urandom_range(1, 12);
        else
            work = $urandom_range(0, 65535);
        return load_item($urandom_range(SLOTS - 1), $urandom_range(255), prio, work);
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    endtask

    // Receiver side: random stall and result check, sampled at the rising edge.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                note_mismatch("unexpected result beat", 32'h0, 32'(rsp));
            end
            else
            begin
                sched_exp = pending_rsp_q.pop_front();
                if (rsp.selected_id !== sched_exp.selected_id)
                    note_mismatch("selected_id", 32'(sched_exp.selected_id), 32'(rsp.selected_id));
                if (rsp.selected_slot !== sched_exp.selected_slot)
                    note_mismatch("selected_slot", 32'(sched_exp.selected_slot),
                                  32'(rsp.selected_slot));
                if (rsp.idle !== sched_exp.idle)
                    note_mismatch("idle", 32'(sched_exp.idle), 32'(rsp.idle));
                if (rsp.status !== sched_exp.status)
                    note_mismatch("status", 32'(sched_exp.status), 32'(rsp.status));
            end
        end
    end

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_beat(input ssch_pkg::req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_rsp_q.push_back(sched_predict(r));
    endtask

    task automatic wait_results_drained();
        if (req_valid)
        begin
            req_valid <= 1'b0;
        end
        while (pending_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Only while idle: every result has been taken.
    task automatic write_stride_constant(input logic [ssch_pkg::STRIDE_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        stride_const = value;
    endtask

    task automatic test_empty_table();
        send_beat(tick_item());
        send_beat(load_item(3, 8'h5A, 0, 7));   // zero priority: rejected, table unchanged
        send_beat(tick_item());
    endtask

    task automatic test_load_extremes();
        send_beat(load_item(0, 8'hFF, 255, 0));      // zero work never qualifies
        send_beat(load_item(7, 8'h00, 1, 16'hFFFF));
        send_beat(load_item(3, 8'hA5, 4, 2));
        repeat (4)
            send_beat(tick_item());
    endtask

    task automatic test_zero_stride_tie();
        // priority above the stride constant gives stride 0; equal keys go to the lower slot
        send_beat(load_item(1, 8'h11, 200, 3));
        send_beat(load_item(2, 8'h22, 255, 3));
        repeat (3)
            send_beat(tick_item());
    endtask

    task automatic test_pass_saturation();
        wait_results_drained();
        write_stride_constant(16'hFFFF);
        send_beat(load_item(7, 8'h77, 9, 0));
        send_beat(load_item(2, 8'h22, 9, 0));
        send_beat(load_item(4, 8'h44, 1, 3));
        send_beat(load_item(5, 8'h55, 2, 3));
        repeat (6)
            send_beat(tick_item());
    endtask

    task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic [ssch_pkg::STRIDE_W-1:0] stride_val,
                                     input int unsigned beats);
        wait_results_drained();
        write_stride_constant(stride_val);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        for (int n = 0; n < beats; n++)
        begin
            if ($urandom_range(49) == 0)
                wait_results_drained();
            send_beat(random_item());
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_load_extremes();
        test_zero_stride_tie();
        test_pass_saturation();
        test_random_phase(0, 0, ssch_pkg::STRIDE_W'($urandom_range(2, 65534)), 406);
        test_random_phase(62, 0, 16'd1, 406);
        test_random_phase(0, 62, 16'hFFFF, 406);
        test_random_phase(27, 27, ssch_pkg::STRIDE_RESET, 406);
        wait_results_drained();
        repeat (SLOTS + 24)
            @(posedge clk);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0)
            $display("stride_scheduler_core_test OK");
        else
            $display("stride_scheduler_core_test NOT OK");
        $finish;
    end

endmodule

FILE: filelist.f
src/ssch_pkg.sv
src/ssch_ram.sv
src/ssch_div.sv
src/stride_scheduler_core.sv
test/stride_scheduler_core_test.sv
